>>> rtl/section_timing_statistics_unit_defines.svh
// assertion macros for the section timing statistics unit
`ifndef SECTION_TIMING_STATISTICS_UNIT_DEFINES_SVH
`define SECTION_TIMING_STATISTICS_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define STS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sts check failed");

// next-cycle implication, checked out of reset
`define STS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sts check failed");

`endif

>>> rtl/sts_pkg.sv
// shared types, constants and helpers for the section timing statistics unit
package sts_pkg;

    localparam int SECTIONS_DEF = 16;
    localparam int HISTORY_DEF  = 8;
    localparam int POS_MAX_W    = 6;
    localparam int FILL_MAX_W   = 7;
    localparam int IN_W         = 40;
    localparam int OUT_W        = 232;

    typedef enum logic [1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_READ  = 2'd2,
        OP_RESET = 2'd3
    } op_t;

    typedef enum logic {
        CFG_ENABLE   = 1'b0,
        CFG_SECTIONS = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0]           start;
        logic [31:0]           count;
        logic [63:0]           total;
        logic [31:0]           min;
        logic [31:0]           max;
        logic [31:0]           last;
        logic [31:0]           avg;
        logic [POS_MAX_W-1:0]  pos;
        logic [FILL_MAX_W-1:0] fill;
    } stats_t;

    function automatic stats_t stats_clear();
        stats_t s;
        s     = '0;
        s.min = '1;
        return s;
    endfunction

endpackage

>>> rtl/sts_ram.sv
// generic single-write, single-read synchronous ram with registered read
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/sts_div.sv
// restoring divider, one quotient bit per cycle
module sts_div #(
    parameter int DW = 38,
    parameter int VW = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg, quo_next;
    logic [VW:0]   rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [VW:0]   rem_sh;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[VW-1:0], quo_reg[DW-1]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CW'(DW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/section_timing_statistics_unit.sv
// section timing statistics unit: per-section interval timing, min, max and history average
//
// usage
//   s_* carries one op per beat: enter, exit, read stats or reset section.
//   m_* returns exactly one result beat per op: status and the slot's stats.
//   cfg_* writes enable (index 0) and sections in use (index 1); the user must
//   write them only while idle, which the block does not enforce.
// sequencing
//   one op at a time; the slot record sits in a ram read, updated, written back.
//   after acceptance an op passes the read, write-back and output states, the
//   result register loading as it leaves output; an out-of-range op skips the
//   write-back. the next op is taken once back in idle. an exit also sums its
//   history from the history ram, then runs a one-bit-per-cycle divider over the sum width.
// reset
//   all slots read as cleared (min all ones) through per-slot valid flops;
//   no clearing pass, the history ram is never cleared.
// stalls
//   a result waits in the output register; the next op is taken meanwhile,
//   and its result waits until the held beat is taken.
`include "section_timing_statistics_unit_defines.svh"

module section_timing_statistics_unit #(
    parameter int SECTIONS = sts_pkg::SECTIONS_DEF,
    parameter int HISTORY  = sts_pkg::HISTORY_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // opcode[1:0], section[5:2], timestamp[37:6], zero pad
    input  logic [sts_pkg::IN_W-1:0] s_tdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // status[0], exit_count[32:1], total_time[96:33], min_time[128:97],
    // max_time[160:129], last_time[192:161], avg_time[224:193],
    // history_fill[228:225], zero pad
    output logic [sts_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [4:0]                cfg_data
);

    localparam int SIDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int HDEPTH = SECTIONS * HISTORY;
    localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int POS_W  = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int FILL_W = $clog2(HISTORY + 1);
    localparam int SUM_W  = 32 + FILL_W;
    localparam int SW     = $bits(sts_pkg::stats_t);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RD   = 7'b0000010,
        ST_SUMA = 7'b0000100,
        ST_SUMB = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_WB   = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    sts_pkg::op_t          op_reg, op_next;
    logic [SIDX_W-1:0]     sec_reg, sec_next;
    logic [31:0]           ts_reg, ts_next;
    logic                  inr_reg, inr_next;
    logic                  status_reg, status_next;
    sts_pkg::stats_t       work_reg, work_next;
    logic [FILL_W-1:0]     idx_reg, idx_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SECTIONS-1:0]   valid_reg, valid_next;
    logic                  enable_reg, enable_next;
    logic [4:0]            siu_reg, siu_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [sts_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    sts_pkg::stats_t       cur;
    sts_pkg::stats_t       stats_q;
    logic [SW-1:0]         stats_rdata;
    logic [SIDX_W-1:0]     stats_raddr;
    logic [3:0]            in_section;
    logic [31:0]           elapsed;
    logic [HAW-1:0]        hist_base;
    logic                  hist_we;
    logic [HAW-1:0]        hist_waddr;
    logic [HAW-1:0]        hist_raddr;
    logic [31:0]           hist_q;
    logic                  div_start;
    logic                  div_done;
    logic [SUM_W-1:0]      div_q;
    logic [POS_W-1:0]      cur_pos;
    logic [FILL_W-1:0]     cur_fill;

    assign in_section  = s_tdata[5:2];
    assign stats_raddr = SIDX_W'(in_section);
    assign stats_q     = sts_pkg::stats_t'(stats_rdata);
    assign cur         = valid_reg[sec_reg] ? stats_q : sts_pkg::stats_clear();
    assign elapsed     = ts_reg - cur.start;
    assign hist_base   = HAW'(HAW'(sec_reg) * HAW'(HISTORY));
    assign cur_pos     = POS_W'(cur.pos);
    assign cur_fill    = FILL_W'(cur.fill);
    assign hist_waddr  = hist_base + HAW'(cur_pos);
    assign hist_raddr  = hist_base + HAW'(idx_reg);
    assign s_tready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        sec_next      = sec_reg;
        ts_next       = ts_reg;
        inr_next      = inr_reg;
        status_next   = status_reg;
        work_next     = work_reg;
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        valid_next    = valid_reg;
        enable_next   = enable_reg;
        siu_next      = siu_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        hist_we       = 1'b0;
        div_start     = 1'b0;

        if (cfg_valid)
        begin
            unique case (sts_pkg::cfg_idx_t'(cfg_index))
                sts_pkg::CFG_ENABLE:   enable_next = cfg_data[0];
                sts_pkg::CFG_SECTIONS: siu_next    = cfg_data;
                default:               enable_next = enable_reg;
            endcase
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = sts_pkg::op_t'(s_tdata[1:0]);
                    sec_next   = SIDX_W'(in_section);
                    ts_next    = s_tdata[37:6];
                    inr_next   = ({1'b0, in_section} < siu_reg)
                                 && (32'(in_section) < SECTIONS);
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                status_next = 1'b0;
                work_next   = cur;
                state_next  = ST_WB;
                if (!inr_reg)
                begin
                    status_next = 1'b1;
                    work_next   = '0;
                    state_next  = ST_OUT;
                end
                else
                begin
                    unique case (op_reg)
                        sts_pkg::OP_ENTER:
                        begin
                            if (enable_reg)
                                work_next.start = ts_reg;
                            else
                                status_next = 1'b1;
                        end
                        sts_pkg::OP_EXIT:
                        begin
                            if (enable_reg)
                            begin
                                hist_we         = 1'b1;
                                work_next.count = cur.count + 32'd1;
                                work_next.total = cur.total + {32'd0, elapsed};
                                work_next.last  = elapsed;
                                if (elapsed < cur.min)
                                    work_next.min = elapsed;
                                if (elapsed > cur.max)
                                    work_next.max = elapsed;
                                if (32'(cur_pos) == HISTORY - 1)
                                    work_next.pos = '0;
                                else
                                    work_next.pos = sts_pkg::POS_MAX_W'(cur_pos)
                                                    + sts_pkg::POS_MAX_W'(1);
                                if (32'(cur_fill) < HISTORY)
                                    work_next.fill = sts_pkg::FILL_MAX_W'(cur_fill)
                                                     + sts_pkg::FILL_MAX_W'(1);
                                idx_next   = '0;
                                sum_next   = '0;
                                state_next = ST_SUMA;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        sts_pkg::OP_READ:  work_next = cur;
                        sts_pkg::OP_RESET: work_next = sts_pkg::stats_clear();
                        default:           work_next = cur;
                    endcase
                end
            end
            ST_SUMA:
            begin
                state_next = ST_SUMB;
            end
            ST_SUMB:
            begin
                sum_next = sum_reg + SUM_W'(hist_q);
                idx_next = idx_reg + FILL_W'(1);
                if (idx_reg + FILL_W'(1) == FILL_W'(work_reg.fill))
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_SUMA;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    work_next.avg = div_q[31:0];
                    state_next    = ST_WB;
                end
            end
            ST_WB:
            begin
                valid_next[sec_reg] = 1'b1;
                state_next          = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'd0, work_reg.fill[3:0], work_reg.avg,
                                     work_reg.last, work_reg.max, work_reg.min,
                                     work_reg.total, work_reg.count, status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            enable_reg   <= 1'b0;
            siu_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            enable_reg   <= enable_next;
            siu_reg      <= siu_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        sec_reg     <= sec_next;
        ts_reg      <= ts_next;
        inr_reg     <= inr_next;
        status_reg  <= status_next;
        work_reg    <= work_next;
        idx_reg     <= idx_next;
        sum_reg     <= sum_next;
        m_tdata_reg <= m_tdata_next;
    end

    sts_ram #(
        .WIDTH (SW),
        .DEPTH (SECTIONS),
        .AW    (SIDX_W)
    ) u_stats_ram (
        .clk   (clk),
        .we    (state_reg == ST_WB),
        .waddr (sec_reg),
        .wdata (SW'(work_reg)),
        .raddr (stats_raddr),
        .rdata (stats_rdata)
    );

    sts_ram #(
        .WIDTH (32),
        .DEPTH (HDEPTH),
        .AW    (HAW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (elapsed),
        .raddr (hist_raddr),
        .rdata (hist_q)
    );

    sts_div #(
        .DW (SUM_W),
        .VW (FILL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (FILL_W'(work_reg.fill)),
        .done     (div_done),
        .quotient (div_q)
    );

    `STS_ASSERT_NEXT(a_accept_reads, s_tvalid && s_tready, state_reg == ST_RD)
    `STS_ASSERT_NOW(a_div_nonzero, state_reg == ST_DIV, work_reg.fill != '0)
    `STS_ASSERT_NEXT(a_out_loads, state_reg == ST_OUT && (!m_tvalid_reg || m_tready),
        m_tvalid_reg && state_reg == ST_IDLE)

endmodule
